>>> hw/rtl/icos_pkg.sv
// icos_pkg: widths, constants and types shared by the icosphere subdivision point block
// no dependencies

package icos_pkg;

  localparam int FRAC_BITS     = 16;
  localparam int MAX_DIVISIONS = 64;

  localparam int CW  = 18;                         // coordinate field width
  localparam int LW  = 7;                          // lattice and divisions width
  localparam int SW  = CW + LW + 1;                // weighted sum width
  localparam int MW  = SW - 1;                     // sum magnitude width
  localparam int NW  = 31;                         // normalized magnitude width
  localparam int SHW = $clog2(NW);                 // normalize shift width
  localparam int PW  = 2 * NW;                     // square width
  localparam int QW  = 64;                         // sum of squares width
  localparam int RW  = QW / 2;                     // root width, one bit per stage
  localparam int RMW = RW + 3;                     // root remainder width
  localparam int DW  = RW + 1;                     // divisor width
  localparam int DRW = DW + 1;                     // divider remainder width
  localparam int QB  = FRAC_BITS + 1;              // quotient bits, one per stage
  localparam int XW  = (QB > CW) ? QB : CW;

  localparam logic [XW-1:0] OUT_MAX = XW'((1 << (CW - 1)) - 1);

  typedef logic [1:0] status_t;
  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_RANGE = 2'd1;
  localparam status_t ST_ZERO  = 2'd2;

  typedef struct packed {
    logic [2:0] neg;
    status_t    st;
  } meta_t;

endpackage

>>> hw/rtl/icosphere_subdivision_point.sv
// icosphere_subdivision_point: one unit-sphere vertex from a coarse triangle and lattice position
// depends on icos_pkg
//
// Takes one item per cycle while in_stall is low. The stages are the weighted corner sum,
// magnitudes and max, normalize shift, normalized magnitudes and squares (five stages), a sum
// of squares register, an exact square root resolved one bit per stage (32 stages), a rounding
// divide resolved one quotient bit per stage for all three axes (one setup plus 17 stages) and
// an output register. The whole pipeline holds while a finished result waits and out_stall is
// high, so in_stall follows out_stall in that case.
// Positions with i+j above divisions (0 read as 1, clamped to 64) give status 1 and zeros, a zero sum gives status 2.

module icosphere_subdivision_point (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [icos_pkg::LW-1:0]       cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [icos_pkg::CW-1:0] corner0_x,
  input  logic signed [icos_pkg::CW-1:0] corner0_y,
  input  logic signed [icos_pkg::CW-1:0] corner0_z,
  input  logic signed [icos_pkg::CW-1:0] corner1_x,
  input  logic signed [icos_pkg::CW-1:0] corner1_y,
  input  logic signed [icos_pkg::CW-1:0] corner1_z,
  input  logic signed [icos_pkg::CW-1:0] corner2_x,
  input  logic signed [icos_pkg::CW-1:0] corner2_y,
  input  logic signed [icos_pkg::CW-1:0] corner2_z,
  input  logic [icos_pkg::LW-1:0]       lattice_i,
  input  logic [icos_pkg::LW-1:0]       lattice_j,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [icos_pkg::CW-1:0] point_x,
  output logic signed [icos_pkg::CW-1:0] point_y,
  output logic signed [icos_pkg::CW-1:0] point_z,
  output logic [1:0]                    status
);
  import icos_pkg::*;

  logic          adv;
  logic [LW-1:0] divisions;
  logic [LW-1:0] n_eff;

  logic signed [CW-1:0] c0 [3];
  logic signed [CW-1:0] c1 [3];
  logic signed [CW-1:0] c2 [3];
  logic [LW-1:0]        w0;
  logic signed [SW-1:0] sum_next [3];
  status_t              st_next;

  // stage a: weighted sum
  logic                 a_v;
  logic signed [SW-1:0] a_sum [3];
  status_t              a_st;
  // stage b: magnitudes and max
  logic          b_v;
  logic [MW-1:0] b_mag [3];
  logic [MW-1:0] b_max;
  meta_t         b_meta;
  // stage c: normalize shift
  logic           c_v;
  logic [MW-1:0]  c_mag [3];
  logic [SHW-1:0] c_sh;
  meta_t          c_meta;
  // stage d: normalized magnitudes
  logic          d_v;
  logic [NW-1:0] d_nmag [3];
  meta_t         d_meta;
  // stage e: squares
  logic          e_v;
  logic [PW-1:0] e_sq [3];
  logic [NW-1:0] e_nmag [3];
  meta_t         e_meta;

  logic           mag_next [3];
  logic [MW-1:0]  bmag_next [3];
  logic [MW-1:0]  bmax_next;
  logic [SHW-1:0] p_next;

  // square root chain
  logic           sq_v    [0:RW];
  logic [QW-1:0]  sq_rad  [0:RW];
  logic [RMW-1:0] sq_rem  [0:RW];
  logic [RW-1:0]  sq_root [0:RW];
  logic [NW-1:0]  sq_mag  [0:RW][3];
  meta_t          sq_meta [0:RW];

  // divide chain
  logic           dv_v    [0:QB];
  logic [DRW-1:0] dv_rem  [0:QB][3];
  logic [QB-1:0]  dv_q    [0:QB][3];
  logic [QB-1:0]  dv_low  [0:QB];
  logic [DW-1:0]  dv_d    [0:QB];
  meta_t          dv_meta [0:QB];

  logic [CW-1:0] pt_next [3];

  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      divisions <= LW'(1);
    end else if (cfg_we) begin
      divisions <= cfg_wdata;
    end
  end

  always_comb begin
    if (divisions == '0) begin
      n_eff = LW'(1);
    end else if (divisions > LW'(MAX_DIVISIONS)) begin
      n_eff = LW'(MAX_DIVISIONS);
    end else begin
      n_eff = divisions;
    end
  end

  assign c0[0] = corner0_x;
  assign c0[1] = corner0_y;
  assign c0[2] = corner0_z;
  assign c1[0] = corner1_x;
  assign c1[1] = corner1_y;
  assign c1[2] = corner1_z;
  assign c2[0] = corner2_x;
  assign c2[1] = corner2_y;
  assign c2[2] = corner2_z;

  always_comb begin
    w0 = n_eff - lattice_i - lattice_j;
    if (({1'b0, lattice_i} + {1'b0, lattice_j}) > {1'b0, n_eff}) begin
      st_next = ST_RANGE;
    end else begin
      st_next = ST_OK;
    end
    for (int k = 0; k < 3; k++) begin
      sum_next[k] = SW'($signed({1'b0, w0})) * SW'(c0[k])
                  + SW'($signed({1'b0, lattice_i})) * SW'(c1[k])
                  + SW'($signed({1'b0, lattice_j})) * SW'(c2[k]);
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mag_next[k]  = a_sum[k][SW-1];
      bmag_next[k] = a_sum[k][SW-1] ? MW'(-a_sum[k]) : MW'(a_sum[k]);
    end
    bmax_next = bmag_next[0];
    if (bmag_next[1] > bmax_next) begin
      bmax_next = bmag_next[1];
    end
    if (bmag_next[2] > bmax_next) begin
      bmax_next = bmag_next[2];
    end
  end

  always_comb begin
    p_next = '0;
    for (int b = 0; b < MW; b++) begin
      if (b_max[b]) begin
        p_next = SHW'(b);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_sum <= sum_next;
      a_st  <= st_next;

      b_mag  <= bmag_next;
      b_max  <= bmax_next;
      b_meta <= '{neg: {mag_next[2], mag_next[1], mag_next[0]}, st: a_st};

      c_mag  <= b_mag;
      c_sh   <= SHW'(NW - 1) - p_next;
      c_meta <= '{neg: b_meta.neg,
                  st: (b_meta.st == ST_OK && b_max == '0) ? ST_ZERO : b_meta.st};

      for (int k = 0; k < 3; k++) begin
        d_nmag[k] <= NW'(c_mag[k]) << c_sh;
        e_sq[k]   <= PW'(d_nmag[k]) * PW'(d_nmag[k]);
      end
      d_meta <= c_meta;
      e_nmag <= d_nmag;
      e_meta <= d_meta;

      sq_rad[0]  <= QW'(e_sq[0]) + QW'(e_sq[1]) + QW'(e_sq[2]);
      sq_rem[0]  <= '0;
      sq_root[0] <= '0;
      sq_mag[0]  <= e_nmag;
      sq_meta[0] <= e_meta;
    end
  end

  genvar t;
  for (t = 0; t < RW; t++) begin : g_sqrt
    logic [RMW-1:0] rem_sh;
    logic [RMW-1:0] trial;
    assign rem_sh = {sq_rem[t][RMW-3:0], sq_rad[t][QW-1:QW-2]};
    assign trial  = RMW'({sq_root[t], 2'b01});
    always_ff @(posedge clk) begin
      if (adv) begin
        sq_rad[t+1]  <= {sq_rad[t][QW-3:0], 2'b00};
        sq_mag[t+1]  <= sq_mag[t];
        sq_meta[t+1] <= sq_meta[t];
        if (rem_sh >= trial) begin
          sq_rem[t+1]  <= rem_sh - trial;
          sq_root[t+1] <= {sq_root[t][RW-2:0], 1'b1};
        end else begin
          sq_rem[t+1]  <= rem_sh;
          sq_root[t+1] <= {sq_root[t][RW-2:0], 1'b0};
        end
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        sq_v[t+1] <= 1'b0;
      end else if (adv) begin
        sq_v[t+1] <= sq_v[t];
      end
    end
  end

  // divide setup: remainder starts at the numerator's top bits, quotient fits QB bits
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        dv_rem[0][k] <= DRW'(sq_mag[RW][k]) + DRW'(sq_root[RW] >> QB);
        dv_q[0][k]   <= '0;
      end
      dv_low[0]  <= sq_root[RW][QB-1:0];
      dv_d[0]    <= {sq_root[RW], 1'b0};
      dv_meta[0] <= sq_meta[RW];
    end
  end

  for (t = 0; t < QB; t++) begin : g_div
    logic [DRW-1:0] rem_sh [3];
    always_comb begin
      for (int k = 0; k < 3; k++) begin
        rem_sh[k] = {dv_rem[t][k][DRW-2:0], dv_low[t][QB-1]};
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        for (int k = 0; k < 3; k++) begin
          if (rem_sh[k] >= DRW'(dv_d[t])) begin
            dv_rem[t+1][k] <= rem_sh[k] - DRW'(dv_d[t]);
            dv_q[t+1][k]   <= {dv_q[t][k][QB-2:0], 1'b1};
          end else begin
            dv_rem[t+1][k] <= rem_sh[k];
            dv_q[t+1][k]   <= {dv_q[t][k][QB-2:0], 1'b0};
          end
        end
        dv_low[t+1]  <= {dv_low[t][QB-2:0], 1'b0};
        dv_d[t+1]    <= dv_d[t];
        dv_meta[t+1] <= dv_meta[t];
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        dv_v[t+1] <= 1'b0;
      end else if (adv) begin
        dv_v[t+1] <= dv_v[t];
      end
    end
  end

  always_comb begin
    logic [XW-1:0] qx;
    for (int k = 0; k < 3; k++) begin
      qx = XW'(dv_q[QB][k]);
      if (qx > OUT_MAX) begin
        qx = OUT_MAX;
      end
      if (dv_meta[QB].st != ST_OK) begin
        pt_next[k] = '0;
      end else if (dv_meta[QB].neg[k]) begin
        pt_next[k] = CW'(-qx);
      end else begin
        pt_next[k] = CW'(qx);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      point_x <= pt_next[0];
      point_y <= pt_next[1];
      point_z <= pt_next[2];
      status  <= dv_meta[QB].st;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v       <= 1'b0;
      b_v       <= 1'b0;
      c_v       <= 1'b0;
      d_v       <= 1'b0;
      e_v       <= 1'b0;
      sq_v[0]   <= 1'b0;
      dv_v[0]   <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      a_v       <= in_valid;
      b_v       <= a_v;
      c_v       <= b_v;
      d_v       <= c_v;
      e_v       <= d_v;
      sq_v[0]   <= e_v;
      dv_v[0]   <= sq_v[RW];
      out_valid <= dv_v[QB];
    end
  end

endmodule
